FILE: rtl/core/ttcg_pkg.sv
// ============================================================================
// ttcg_pkg: shared types and constants for the text terminal cell grid
// Command codes, cell layout and reset values used by the grid core.
// ============================================================================
package ttcg_pkg;

   localparam int DEF_GRID_COLS = 256;
   localparam int DEF_GRID_ROWS = 64;

   localparam logic [2:0] CMD_PUTCHAR = 3'd0;
   localparam logic [2:0] CMD_SETCUR  = 3'd1;
   localparam logic [2:0] CMD_SCRUP   = 3'd2;
   localparam logic [2:0] CMD_SCRDN   = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;
   localparam logic [2:0] CMD_MOVE    = 3'd5;
   localparam logic [2:0] CMD_READ    = 3'd6;

   localparam logic [2:0] REG_COLUMNS  = 3'd0;
   localparam logic [2:0] REG_ROWS     = 3'd1;
   localparam logic [2:0] REG_STOP     = 3'd2;
   localparam logic [2:0] REG_SBOT     = 3'd3;
   localparam logic [2:0] REG_WRAP_EN  = 3'd4;
   localparam logic [2:0] REG_SCROLL_EN = 3'd5;

   localparam logic [7:0]  BLANK_CHAR = 8'h20;
   localparam logic [23:0] RESET_FG   = 24'hD7FFD7;
   localparam logic [23:0] RESET_BG   = 24'h000000;

   typedef struct packed {
      logic [7:0]  ch;
      logic [23:0] fg;
      logic [23:0] bg;
   } cell_type;

endpackage

FILE: rtl/core/text_terminal_cell_grid.sv
// ============================================================================
// text_terminal_cell_grid: character-cell terminal store
// Keeps a grid of character cells and a cursor, and applies one command at a
// time: putchar, set cursor, scroll, clear, move cell and read cell.
// ============================================================================
// A command is taken when start is high and busy is low; busy stays high
// until its one result word is shown with done for a single cycle, and that
// word must be taken in that cycle. Set cursor, an unused command and a move
// or read at a bad position are settled in the decode state; putchar then
// writes its cell, read reads the cell through the registered memory port,
// and move reads the source cell and then writes it to the target. Busy is
// still high while done is shown, so the next command is taken in the cycle
// after the result at the earliest. A scroll reads and then writes each of
// (rows in region - 1)*columns cells and then blanks one row, and clear
// blanks rows*columns cells, since every cell passes through the single port
// of the cell memory. After reset the memory is cleared to blanks, one entry
// at a time over all 16384 entries at the default size, while busy is high;
// configuration writes are accepted throughout.
module text_terminal_cell_grid
   import ttcg_pkg::*;
#(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_ch,
   input  logic [23:0] req_fg_colour,
   input  logic [23:0] req_bg_colour,
   input  logic signed [10:0] req_pos_x,
   input  logic signed [10:0] req_pos_y,
   input  logic [7:0]  req_src_x,
   input  logic [5:0]  req_src_y,
   input  logic        req_clear_home,
   output logic        done,
   output logic [7:0]  rsp_cell_char,
   output logic [23:0] rsp_cell_fg,
   output logic [23:0] rsp_cell_bg,
   output logic [7:0]  rsp_cursor_col,
   output logic [5:0]  rsp_cursor_row,
   output logic        rsp_did_scroll,
   output logic        rsp_bad_position,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int AW = CW + RW;
   localparam int DEPTH = 1 << AW;
   localparam logic [9:0] MAXC10 = 10'(GRID_COLS);
   localparam logic [8:0] MAXR9  = 9'(GRID_ROWS);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DEC   = 4'd2;
   localparam logic [3:0] S_SRD   = 4'd3;
   localparam logic [3:0] S_SWR   = 4'd4;
   localparam logic [3:0] S_BLNK  = 4'd5;
   localparam logic [3:0] S_PUT   = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_RDW   = 4'd8;
   localparam logic [3:0] S_MVW   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   // Configuration registers.
   logic [8:0] columns_ff;
   logic [6:0] rows_ff;
   logic [5:0] stop_ff;
   logic [6:0] sbot_ff;
   logic       wrap_en_ff, scroll_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= 9'd80;
         rows_ff <= 7'd25;
         stop_ff <= 6'd0;
         sbot_ff <= 7'd25;
         wrap_en_ff <= 1'b1;
         scroll_en_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_COLUMNS:   columns_ff <= csr_wdata;
            REG_ROWS:      rows_ff <= csr_wdata[6:0];
            REG_STOP:      stop_ff <= csr_wdata[5:0];
            REG_SBOT:      sbot_ff <= csr_wdata[6:0];
            REG_WRAP_EN:   wrap_en_ff <= csr_wdata[0];
            REG_SCROLL_EN: scroll_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective grid size, 1 to MAX.
   logic [9:0] cols;
   logic [8:0] rows;
   always_comb begin
      if (columns_ff == 9'd0) cols = 10'd1;
      else if ({1'b0, columns_ff} > MAXC10) cols = MAXC10;
      else cols = {1'b0, columns_ff};
      if (rows_ff == 7'd0) rows = 9'd1;
      else if ({2'b0, rows_ff} > MAXR9) rows = MAXR9;
      else rows = {2'b0, rows_ff};
   end
   logic [9:0] cols_m1;
   logic [8:0] rows_m1;
   assign cols_m1 = cols - 10'd1;
   assign rows_m1 = rows - 9'd1;
   logic margins_ok;
   assign margins_ok = ({2'b0, sbot_ff} > {3'b0, stop_ff}) && ({2'b0, sbot_ff} <= rows);

   // Cell memory: one port, registered read.
   cell_type mem [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   cell_type      mem_wd, mem_rd_ff;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      mem_rd_ff <= mem[mem_addr];
   end

   // Sequencer state.
   logic [3:0]    state_ff, state_in;
   logic [9:0]    ccol_ff, ccol_in;
   logic [8:0]    crow_ff, crow_in;
   logic [2:0]    cmd_ff;
   logic [7:0]    ch_ff;
   logic [23:0]   fg_ff, bg_ff;
   logic signed [10:0] px_ff, py_ff;
   logic [7:0]    sx_ff;
   logic [5:0]    sy_ff;
   logic          home_ff;
   logic [CW-1:0] x_ff, x_in;
   logic [RW-1:0] y_ff, y_in;
   logic [RW-1:0] yend_ff, yend_in;
   logic          dir_ff, dir_in;
   logic          put_after_ff, put_after_in;
   logic          scrl_ff, scrl_in, bad_ff, bad_in;
   cell_type      rdc_ff, rdc_in;
   logic [AW-1:0] init_ff;

   assign busy = (state_ff != S_IDLE);

   // Range checks on the latched position fields.
   logic pos_ok, src_ok;
   assign pos_ok = !px_ff[10] && !py_ff[10] && ({1'b0, px_ff[9:0]} < {1'b0, cols}) &&
                   ({2'b0, py_ff[9:0]} < {3'b0, rows});
   assign src_ok = ({2'b0, sx_ff} < cols) && ({3'b0, sy_ff} < rows);

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return {r, c};
   endfunction

   logic [CW-1:0] x_last;
   assign x_last = cols_m1[CW-1:0];
   logic x_at_end;
   assign x_at_end = (x_ff == x_last);

   // Deferred wrap decision for putchar, on the row after stale-row clamp.
   logic [8:0] prow;
   logic       wrap_go, wrap_scroll;
   logic [8:0] wrap_row;
   always_comb begin
      prow = (crow_ff >= rows) ? rows_m1 : crow_ff;
      wrap_go = wrap_en_ff && ((sbot_ff == 7'd0) ||
                ({2'b0, prow} < {3'b0, sbot_ff} - 11'd1) || scroll_en_ff);
      wrap_scroll = ((prow + 9'd1) == {2'b0, sbot_ff});
      wrap_row = wrap_scroll ? prow : prow + 9'd1;
      if (wrap_row >= rows) wrap_row = rows_m1;
   end

   always_comb begin
      state_in = state_ff;
      ccol_in = ccol_ff;
      crow_in = crow_ff;
      x_in = x_ff;
      y_in = y_ff;
      yend_in = yend_ff;
      dir_in = dir_ff;
      put_after_in = put_after_ff;
      scrl_in = scrl_ff;
      bad_in = bad_ff;
      rdc_in = rdc_ff;
      mem_we = 1'b0;
      mem_addr = addr_of(y_ff, x_ff);
      mem_wd = '{ch: BLANK_CHAR, fg: fg_ff, bg: bg_ff};
      unique case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            mem_addr = init_ff;
            mem_wd = '{ch: BLANK_CHAR, fg: RESET_FG, bg: RESET_BG};
            if (init_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_DEC;
               scrl_in = 1'b0;
               bad_in = 1'b0;
               rdc_in = '0;
               put_after_in = 1'b0;
            end
         end
         S_DEC: begin
            state_in = S_DONE;
            unique case (cmd_ff) inside
               CMD_PUTCHAR: begin
                  crow_in = prow;
                  state_in = S_PUT;
                  if (ccol_ff >= cols) begin
                     if (wrap_go) begin
                        ccol_in = 10'd0;
                        crow_in = wrap_row;
                        if (wrap_scroll && margins_ok) begin
                           scrl_in = 1'b1;
                           put_after_in = 1'b1;
                           dir_in = 1'b0;
                           x_in = '0;
                           y_in = stop_ff[RW-1:0];
                           yend_in = RW'(sbot_ff - 7'd1);
                           state_in = (RW'(stop_ff) == RW'(sbot_ff - 7'd1)) ? S_BLNK : S_SRD;
                        end
                     end else begin
                        ccol_in = cols_m1;
                     end
                  end
               end
               CMD_SETCUR: begin
                  if (px_ff[10]) ccol_in = 10'd0;
                  else if (px_ff[9:0] >= cols) ccol_in = cols_m1;
                  else ccol_in = px_ff[9:0];
                  if (py_ff[10]) crow_in = 9'd0;
                  else if ({1'b0, py_ff[9:0]} >= {2'b0, rows}) crow_in = rows_m1;
                  else crow_in = py_ff[8:0];
               end
               CMD_SCRUP, CMD_SCRDN: begin
                  if (margins_ok) begin
                     dir_in = (cmd_ff == CMD_SCRDN);
                     x_in = '0;
                     if (cmd_ff == CMD_SCRDN) begin
                        y_in = RW'(sbot_ff - 7'd1);
                        yend_in = stop_ff[RW-1:0];
                     end else begin
                        y_in = stop_ff[RW-1:0];
                        yend_in = RW'(sbot_ff - 7'd1);
                     end
                     state_in = (RW'(stop_ff) == RW'(sbot_ff - 7'd1)) ? S_BLNK : S_SRD;
                  end
               end
               CMD_CLEAR: begin
                  x_in = '0;
                  y_in = '0;
                  yend_in = rows_m1[RW-1:0];
                  dir_in = 1'b0;
                  state_in = S_BLNK;
                  if (home_ff) begin
                     ccol_in = 10'd0;
                     crow_in = 9'd0;
                  end
               end
               CMD_MOVE: begin
                  if (!(pos_ok && src_ok)) bad_in = 1'b1;
                  else state_in = S_RD;
               end
               CMD_READ: begin
                  if (!pos_ok) bad_in = 1'b1;
                  else state_in = S_RD;
               end
               default: ;
            endcase
         end
         // Scroll copy: read the neighbor row's cell, then write it here.
         S_SRD: begin
            mem_addr = addr_of(dir_ff ? y_ff - RW'(1) : y_ff + RW'(1), x_ff);
            state_in = S_SWR;
         end
         S_SWR: begin
            mem_we = 1'b1;
            mem_wd = mem_rd_ff;
            state_in = S_SRD;
            if (x_at_end) begin
               x_in = '0;
               y_in = dir_ff ? y_ff - RW'(1) : y_ff + RW'(1);
               if ((dir_ff ? y_ff - RW'(1) : y_ff + RW'(1)) == yend_ff) state_in = S_BLNK;
            end else begin
               x_in = x_ff + CW'(1);
            end
         end
         // Blank row y (through yend for clear).
         S_BLNK: begin
            mem_we = 1'b1;
            if (x_at_end) begin
               x_in = '0;
               if (cmd_ff == CMD_CLEAR && y_ff != yend_ff) y_in = y_ff + RW'(1);
               else state_in = put_after_ff ? S_PUT : S_DONE;
            end else begin
               x_in = x_ff + CW'(1);
            end
         end
         S_PUT: begin
            mem_we = 1'b1;
            mem_addr = addr_of(crow_ff[RW-1:0], ccol_ff[CW-1:0]);
            mem_wd = '{ch: ch_ff, fg: fg_ff, bg: bg_ff};
            ccol_in = ccol_ff + 10'd1;
            state_in = S_DONE;
         end
         S_RD: begin
            if (cmd_ff == CMD_MOVE) mem_addr = addr_of(sy_ff[RW-1:0], sx_ff[CW-1:0]);
            else mem_addr = addr_of(py_ff[RW-1:0], px_ff[CW-1:0]);
            state_in = S_RDW;
         end
         S_RDW: begin
            if (cmd_ff == CMD_MOVE) begin
               state_in = S_MVW;
               rdc_in = mem_rd_ff;
            end else begin
               rdc_in = mem_rd_ff;
               state_in = S_DONE;
            end
         end
         S_MVW: begin
            mem_we = 1'b1;
            mem_addr = addr_of(py_ff[RW-1:0], px_ff[CW-1:0]);
            mem_wd = rdc_ff;
            rdc_in = '0;
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff <= '0;
         ccol_ff <= '0;
         crow_ff <= '0;
      end else begin
         state_ff <= state_in;
         init_ff <= init_ff + AW'(1);
         ccol_ff <= ccol_in;
         crow_ff <= crow_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      yend_ff <= yend_in;
      dir_ff <= dir_in;
      put_after_ff <= put_after_in;
      scrl_ff <= scrl_in;
      bad_ff <= bad_in;
      rdc_ff <= rdc_in;
      if (state_ff == S_IDLE && start) begin
         cmd_ff <= req_cmd;
         ch_ff <= req_ch;
         fg_ff <= req_fg_colour;
         bg_ff <= req_bg_colour;
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         sx_ff <= req_src_x;
         sy_ff <= req_src_y;
         home_ff <= req_clear_home;
      end
   end

   // Result word, shown during the done cycle.
   logic [9:0] out_col;
   logic [8:0] out_row;
   assign out_col = (ccol_ff >= cols) ? cols_m1 : ccol_ff;
   assign out_row = (crow_ff >= rows) ? rows_m1 : crow_ff;
   assign done = (state_ff == S_DONE);
   assign rsp_cell_char = rdc_ff.ch;
   assign rsp_cell_fg = rdc_ff.fg;
   assign rsp_cell_bg = rdc_ff.bg;
   assign rsp_cursor_col = out_col[7:0];
   assign rsp_cursor_row = out_row[5:0];
   assign rsp_did_scroll = scrl_ff;
   assign rsp_bad_position = bad_ff;

endmodule

FILE: sim/text_terminal_cell_grid_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// text_terminal_cell_grid_tb: self-checking bench for the cell grid
// Drives directed and random commands through several grid settings, keeps
// its own copy of the grid and cursor, and checks every result word.
// ============================================================================
module text_terminal_cell_grid_tb
   import ttcg_pkg::*;
;

   localparam int NCOLS      = DEF_GRID_COLS;
   localparam int NROWS      = DEF_GRID_ROWS;
   localparam int CYCLE_CAP  = 3000000;
   localparam int TAIL_WAIT  = 40;

   typedef struct {
      logic [2:0]         cmd;
      logic [7:0]         ch;
      logic [23:0]        fg;
      logic [23:0]        bg;
      logic signed [10:0] px;
      logic signed [10:0] py;
      logic [7:0]         sx;
      logic [5:0]         sy;
      logic               home;
   } grid_cmd_type;

   typedef struct {
      logic [7:0]  ch;
      logic [23:0] fg;
      logic [23:0] bg;
      logic [7:0]  col;
      logic [5:0]  row;
      logic        scr;
      logic        bad;
   } grid_reply_type;

   typedef struct {
      grid_cmd_type   c;
      bit             typed;
      grid_reply_type r;
   } table_row_type;

   // Block ports.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_cmd = CMD_READ;
   logic [7:0]  req_ch = '0;
   logic [23:0] req_fg_colour = '0;
   logic [23:0] req_bg_colour = '0;
   logic signed [10:0] req_pos_x = '0;
   logic signed [10:0] req_pos_y = '0;
   logic [7:0]  req_src_x = '0;
   logic [5:0]  req_src_y = '0;
   logic        req_clear_home = 1'b0;
   logic        done;
   logic [7:0]  rsp_cell_char;
   logic [23:0] rsp_cell_fg;
   logic [23:0] rsp_cell_bg;
   logic [7:0]  rsp_cursor_col;
   logic [5:0]  rsp_cursor_row;
   logic        rsp_did_scroll;
   logic        rsp_bad_position;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_COLUMNS;
   logic [8:0]  csr_wdata = '0;

   // Shadow copy of the grid, cursor and registers.
   cell_type    shadow_grid [NCOLS*NROWS];
   int          sh_col, sh_row;
   int          r_cols, r_rows, r_top, r_bot, r_wrap, r_scroll;

   grid_reply_type pending_replies [$];
   table_row_type  dir_tab [$];
   int          errors = 0;
   int          cycles = 0;

   text_terminal_cell_grid u_top (.*);

   // Clock: 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int cols_eff();
      if (r_cols == 0) return 1;
      return (r_cols > NCOLS) ? NCOLS : r_cols;
   endfunction

   function automatic int rows_eff();
      if (r_rows == 0) return 1;
      return (r_rows > NROWS) ? NROWS : r_rows;
   endfunction

   function automatic void blank_line(int y, cell_type blank);
      for (int x = 0; x < cols_eff(); x++) shadow_grid[y*NCOLS + x] = blank;
   endfunction

   // Shifts the scroll region by one row; returns 0 when the margins are invalid.
   function automatic bit shift_region(bit down, cell_type blank);
      int n;
      n = cols_eff();
      if (r_bot <= r_top || r_bot > rows_eff()) return 1'b0;
      if (!down) begin
         for (int y = r_top; y + 1 < r_bot; y++)
            for (int x = 0; x < n; x++)
               shadow_grid[y*NCOLS + x] = shadow_grid[(y+1)*NCOLS + x];
         blank_line(r_bot - 1, blank);
      end else begin
         for (int y = r_bot - 1; y > r_top; y--)
            for (int x = 0; x < n; x++)
               shadow_grid[y*NCOLS + x] = shadow_grid[(y-1)*NCOLS + x];
         blank_line(r_top, blank);
      end
      return 1'b1;
   endfunction

   // Applies one command word to the shadow grid and returns the expected reply.
   function automatic grid_reply_type apply_cmd(grid_cmd_type c);
      int cols, rows, y, px, py;
      cell_type blank;
      grid_reply_type r;
      cols = cols_eff();
      rows = rows_eff();
      px = c.px;
      py = c.py;
      blank = '{ch: BLANK_CHAR, fg: c.fg, bg: c.bg};
      r = '{default: '0};
      case (c.cmd)
         CMD_PUTCHAR: begin
            if (sh_row >= rows) sh_row = rows - 1;
            if (sh_col >= cols) begin
               // Deferred wrap; with wrap enabled, a bottom margin of zero always lets it through.
               if (r_wrap != 0 && (r_bot == 0 || sh_row < r_bot - 1 || r_scroll != 0)) begin
                  y = sh_row + 1;
                  sh_col = 0;
                  if (y == r_bot) begin
                     y--;
                     r.scr = shift_region(1'b0, blank);
                  end
                  if (y >= rows) y = rows - 1;
                  sh_row = y;
               end else begin
                  sh_col = cols - 1;
               end
            end
            shadow_grid[sh_row*NCOLS + sh_col] = '{ch: c.ch, fg: c.fg, bg: c.bg};
            sh_col++;
         end
         CMD_SETCUR: begin
            sh_col = (px < 0) ? 0 : ((px >= cols) ? cols - 1 : px);
            sh_row = (py < 0) ? 0 : ((py >= rows) ? rows - 1 : py);
         end
         CMD_SCRUP: void'(shift_region(1'b0, blank));
         CMD_SCRDN: void'(shift_region(1'b1, blank));
         CMD_CLEAR: begin
            for (int yy = 0; yy < rows; yy++) blank_line(yy, blank);
            if (c.home) begin
               sh_col = 0;
               sh_row = 0;
            end
         end
         CMD_MOVE: begin
            if (c.sx >= cols || c.sy >= rows || px < 0 || py < 0 || px >= cols || py >= rows)
               r.bad = 1'b1;
            else
               shadow_grid[py*NCOLS + px] = shadow_grid[c.sy*NCOLS + c.sx];
         end
         CMD_READ: begin
            if (px < 0 || py < 0 || px >= cols || py >= rows) begin
               r.bad = 1'b1;
            end else begin
               r.ch = shadow_grid[py*NCOLS + px].ch;
               r.fg = shadow_grid[py*NCOLS + px].fg;
               r.bg = shadow_grid[py*NCOLS + px].bg;
            end
         end
         default: ;
      endcase
      r.col = 8'((sh_col >= cols) ? cols - 1 : sh_col);
      r.row = 6'((sh_row >= rows) ? rows - 1 : sh_row);
      return r;
   endfunction

   // Result checker: every done word is matched against the oldest expectation.
   always @(posedge clock) begin
      grid_reply_type e;
      if (!reset && done) begin
         if (pending_replies.size() == 0) begin
            $error("result word with no expectation pending");
            errors++;
         end else begin
            e = pending_replies.pop_front();
            if (rsp_cell_char !== e.ch) begin
               $error("cell_char expected %h got %h", e.ch, rsp_cell_char);
               errors++;
            end
            if (rsp_cell_fg !== e.fg) begin
               $error("cell_fg expected %h got %h", e.fg, rsp_cell_fg);
               errors++;
            end
            if (rsp_cell_bg !== e.bg) begin
               $error("cell_bg expected %h got %h", e.bg, rsp_cell_bg);
               errors++;
            end
            if (rsp_cursor_col !== e.col) begin
               $error("cursor_col expected %0d got %0d", e.col, rsp_cursor_col);
               errors++;
            end
            if (rsp_cursor_row !== e.row) begin
               $error("cursor_row expected %0d got %0d", e.row, rsp_cursor_row);
               errors++;
            end
            if (rsp_did_scroll !== e.scr) begin
               $error("did_scroll expected %b got %b", e.scr, rsp_did_scroll);
               errors++;
            end
            if (rsp_bad_position !== e.bad) begin
               $error("bad_position expected %b got %b", e.bad, rsp_bad_position);
               errors++;
            end
         end
      end
   end

   // Register write; the shadow registers follow.
   task automatic write_reg(logic [2:0] idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[8:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_COLUMNS:   r_cols   = val & 9'h1FF;
         REG_ROWS:      r_rows   = val & 7'h7F;
         REG_STOP:      r_top    = val & 6'h3F;
         REG_SBOT:      r_bot    = val & 7'h7F;
         REG_WRAP_EN:   r_wrap   = val & 1;
         REG_SCROLL_EN: r_scroll = val & 1;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Drives one command word and holds it until accepted. The typed reply,
   // where given, replaces the shadow prediction.
   task automatic send_word(grid_cmd_type c, bit typed, grid_reply_type tr, int idle_pct);
      grid_reply_type p;
      start          <= 1'b1;
      req_cmd        <= c.cmd;
      req_ch         <= c.ch;
      req_fg_colour  <= c.fg;
      req_bg_colour  <= c.bg;
      req_pos_x      <= c.px;
      req_pos_y      <= c.py;
      req_src_x      <= c.sx;
      req_src_y      <= c.sy;
      req_clear_home <= c.home;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = apply_cmd(c);
      pending_replies.push_back(typed ? tr : p);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic program_grid(int cols, int rows, int top, int bot, int wr, int sc);
      start <= 1'b0;
      wait_drained();
      @(posedge clock);
      write_reg(REG_COLUMNS, cols);
      write_reg(REG_ROWS, rows);
      write_reg(REG_STOP, top);
      write_reg(REG_SBOT, bot);
      write_reg(REG_WRAP_EN, wr);
      write_reg(REG_SCROLL_EN, sc);
   endtask

   function automatic grid_cmd_type mk_cmd(logic [2:0] cmd, logic [7:0] ch, logic [23:0] fg,
                                           logic [23:0] bg, int px, int py, int sx, int sy,
                                           bit home);
      grid_cmd_type c;
      c = '{cmd: cmd, ch: ch, fg: fg, bg: bg, px: px[10:0], py: py[10:0],
            sx: sx[7:0], sy: sy[5:0], home: home};
      return c;
   endfunction

   function automatic grid_reply_type mk_reply(int ch, int fg, int bg, int col, int row,
                                               bit scr, bit bad);
      grid_reply_type r;
      r = '{ch: ch[7:0], fg: fg[23:0], bg: bg[23:0], col: col[7:0], row: row[5:0],
            scr: scr, bad: bad};
      return r;
   endfunction

   function automatic void add_row(grid_cmd_type c, bit typed, grid_reply_type r);
      table_row_type t;
      t.c = c;
      t.typed = typed;
      t.r = r;
      dir_tab.push_back(t);
   endfunction

   // Random command word; heavy commands are rare, and absent when light is set.
   function automatic grid_cmd_type rand_cmd(bit light);
      grid_cmd_type c;
      int sel, cols, rows;
      cols = cols_eff();
      rows = rows_eff();
      sel = $urandom_range(99);
      c.ch = 8'($urandom);
      c.fg = 24'($urandom);
      c.bg = 24'($urandom);
      c.home = 1'($urandom_range(1));
      if (sel < 50)                      c.cmd = CMD_PUTCHAR;
      else if (sel < 62)                 c.cmd = CMD_SETCUR;
      else if (sel < 78)                 c.cmd = CMD_READ;
      else if (sel < 90)                 c.cmd = CMD_MOVE;
      else if (light)                    c.cmd = CMD_READ;
      else if (sel < 94)                 c.cmd = CMD_SCRUP;
      else if (sel < 97)                 c.cmd = CMD_SCRDN;
      else                               c.cmd = CMD_CLEAR;
      if ($urandom_range(9) == 0) begin
         c.px = 11'($urandom);
         c.py = 11'($urandom);
         c.sx = 8'($urandom);
         c.sy = 6'($urandom);
      end else begin
         c.px = 11'(int'($urandom_range(cols + 1)) - 1);
         c.py = 11'(int'($urandom_range(rows + 1)) - 1);
         c.sx = 8'((cols > 255) ? $urandom_range(255) : $urandom_range(cols));
         c.sy = 6'((rows > 63) ? $urandom_range(63) : $urandom_range(rows));
         // Aim set cursor near the far corner so wraps and scrolls come often.
         if (c.cmd == CMD_SETCUR && $urandom_range(1)) begin
            c.px = 11'(cols - 1 - int'($urandom_range(1)));
            c.py = 11'(rows - 1 - int'($urandom_range(1)));
         end
      end
      return c;
   endfunction

   task automatic run_random(int count, bit light);
      grid_reply_type none;
      none = '{default: '0};
      for (int i = 0; i < count; i++) begin
         int pct;
         pct = (i < count/3) ? 31 : ((i < 2*count/3) ? 84 : 0);
         if (i == count/2) begin
            // Hold the sender off until every result word is back.
            start <= 1'b0;
            wait_drained();
            @(posedge clock);
         end
         send_word(rand_cmd(light), 1'b0, none, pct);
      end
   endtask

   initial begin
      grid_reply_type none;
      none = '{default: '0};
      for (int i = 0; i < NCOLS*NROWS; i++)
         shadow_grid[i] = '{ch: BLANK_CHAR, fg: RESET_FG, bg: RESET_BG};
      sh_col = 0;
      sh_row = 0;
      r_cols = 80; r_rows = 25; r_top = 0; r_bot = 25; r_wrap = 1; r_scroll = 1;

      // Directed table at the reset settings.
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_reply(BLANK_CHAR, RESET_FG, RESET_BG, 0, 0, 0, 0));
      add_row(mk_cmd(CMD_READ, 0, 0, 0, -1024, 0, 0, 0, 0), 1, mk_reply(0, 0, 0, 0, 0, 0, 1));
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 1023, 0, 0, 0), 1, mk_reply(0, 0, 0, 0, 0, 0, 1));
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 80, 0, 0, 0, 0), 1, mk_reply(0, 0, 0, 0, 0, 0, 1));
      add_row(mk_cmd(CMD_SETCUR, 0, 0, 0, -1024, -1024, 0, 0, 0), 1,
              mk_reply(0, 0, 0, 0, 0, 0, 0));
      add_row(mk_cmd(CMD_SETCUR, 0, 0, 0, 1023, 1023, 0, 0, 0), 1,
              mk_reply(0, 0, 0, 79, 24, 0, 0));
      add_row(mk_cmd(CMD_PUTCHAR, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0, 0), 1,
              mk_reply(0, 0, 0, 79, 24, 0, 0));
      // The pending wrap on the last row scrolls the whole screen.
      add_row(mk_cmd(CMD_PUTCHAR, 8'h00, 24'h000000, 24'h000000, 0, 0, 0, 0, 0), 1,
              mk_reply(0, 0, 0, 1, 24, 1, 0));
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 79, 23, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 24, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 79, 24, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_MOVE, 0, 0, 0, 0, 0, 79, 23, 0), 0, none);
      add_row(mk_cmd(CMD_MOVE, 0, 0, 0, 3, 3, 255, 0, 0), 1, mk_reply(0, 0, 0, 1, 24, 0, 1));
      add_row(mk_cmd(CMD_MOVE, 0, 0, 0, 3, 3, 0, 63, 0), 1, mk_reply(0, 0, 0, 1, 24, 0, 1));
      add_row(mk_cmd(CMD_MOVE, 0, 0, 0, -1, 3, 0, 0, 0), 1, mk_reply(0, 0, 0, 1, 24, 0, 1));
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_SCRDN, 0, 24'h123456, 24'hABCDEF, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 5, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_SCRUP, 0, 24'h654321, 24'hFEDCBA, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_CLEAR, 0, 24'h0F0F0F, 24'hF0F0F0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 79, 24, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_CLEAR, 0, 24'h000000, 24'hFFFFFF, 0, 0, 0, 0, 1), 0, none);
      add_row(mk_cmd(CMD_PUTCHAR, 8'h41, 24'hAAAAAA, 24'h555555, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);

      // Reset is held high before the directed table runs.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) send_word(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r, 31);

      // Random phases over several grid settings.
      program_grid(8, 6, 1, 5, 1, 1);
      run_random(90, 0);
      program_grid(1, 1, 0, 1, 1, 1);
      run_random(30, 0);
      program_grid(12, 10, 0, 0, 1, 1);
      run_random(70, 0);
      program_grid(6, 5, 3, 2, 1, 0);
      run_random(50, 0);
      program_grid(10, 8, 2, 6, 1, 0);
      run_random(70, 0);
      program_grid(7, 6, 0, 6, 0, 1);
      run_random(50, 0);
      program_grid(4, 64, 60, 64, 1, 1);
      run_random(50, 0);
      program_grid(5, 4, 0, 9, 1, 1);
      run_random(40, 0);
      program_grid(256, 64, 0, 64, 1, 1);
      send_word(mk_cmd(CMD_SETCUR, 0, 0, 0, 255, 63, 0, 0, 0), 0, none, 0);
      send_word(mk_cmd(CMD_PUTCHAR, 8'h7E, 24'h00FF00, 24'h0000FF, 0, 0, 0, 0, 0), 0, none, 0);
      send_word(mk_cmd(CMD_PUTCHAR, 8'h81, 24'hFF0000, 24'h00FF00, 0, 0, 0, 0, 0), 0, none, 0);
      send_word(mk_cmd(CMD_READ, 0, 0, 0, 255, 62, 0, 0, 0), 0, none, 0);
      send_word(mk_cmd(CMD_CLEAR, 0, 24'h111111, 24'h222222, 0, 0, 0, 0, 1), 0, none, 0);
      run_random(30, 1);
      program_grid(80, 25, 0, 25, 1, 1);
      run_random(40, 0);

      // Drain and settle, then report.
      start <= 1'b0;
      wait_drained();
      repeat (TAIL_WAIT) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/ttcg_pkg.sv
rtl/core/text_terminal_cell_grid.sv
sim/text_terminal_cell_grid_tb.sv
